// ===== hdl/tbcr_pkg.sv =====
// Package for the two-button chord router.
// Holds item types, event and action codes and the event-to-action map.
// No dependencies.
package tbcr_pkg;

  localparam int unsigned MaxActs = 4;
  localparam int unsigned CntW    = $clog2(MaxActs + 1);
  localparam int unsigned SlotW   = $clog2(MaxActs);

  localparam logic [15:0] WIN_RESET = 16'd300;

  localparam logic [3:0] EV_NONE             = 4'd0;
  localparam logic [3:0] EV_CLICK            = 4'd1;
  localparam logic [3:0] EV_DOUBLE           = 4'd2;
  localparam logic [3:0] EV_TRIPLE           = 4'd3;
  localparam logic [3:0] EV_HOLD_START       = 4'd4;
  localparam logic [3:0] EV_HOLD_END         = 4'd5;
  localparam logic [3:0] EV_CLICK_HOLD_START = 4'd6;
  localparam logic [3:0] EV_CLICK_HOLD_END   = 4'd7;
  localparam logic [3:0] EV_PAIRING          = 4'd8;

  localparam logic [1:0] LAMP_ONE   = 2'd0;
  localparam logic [1:0] LAMP_TWO   = 2'd1;
  localparam logic [1:0] LAMP_THREE = 2'd2;

  localparam logic [2:0] ACT_TOGGLE       = 3'd0;
  localparam logic [2:0] ACT_LEVEL_START  = 3'd1;
  localparam logic [2:0] ACT_LEVEL_STOP   = 3'd2;
  localparam logic [2:0] ACT_COLOUR_START = 3'd3;
  localparam logic [2:0] ACT_COLOUR_STOP  = 3'd4;
  localparam logic [2:0] ACT_EMPTY        = 3'd5;
  localparam logic [2:0] ACT_PAIRING      = 3'd6;

  typedef struct packed {
    logic [3:0]  button1_event;
    logic [3:0]  button2_event;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] target_lamp;
    logic [2:0] action;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] lamp;
    logic [2:0] action;
  } act_slot_t;

  typedef struct packed {
    logic [CntW-1:0]           count;
    act_slot_t [MaxActs-1:0]   slots;
  } bundle_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] code;
  } act_map_t;

  function automatic act_map_t action_of(logic [3:0] ev);
    act_map_t r;
    r.vld  = 1'b1;
    r.code = ACT_TOGGLE;
    case (ev)
      EV_CLICK:            r.code = ACT_TOGGLE;
      EV_DOUBLE:           r.code = ACT_EMPTY;
      EV_TRIPLE:           r.code = ACT_EMPTY;
      EV_HOLD_START:       r.code = ACT_LEVEL_START;
      EV_HOLD_END:         r.code = ACT_LEVEL_STOP;
      EV_CLICK_HOLD_START: r.code = ACT_COLOUR_START;
      EV_CLICK_HOLD_END:   r.code = ACT_COLOUR_STOP;
      EV_PAIRING:          r.code = ACT_PAIRING;
      default:             r.vld  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] clean_event(logic [3:0] ev);
    return (ev > EV_PAIRING) ? EV_NONE : ev;
  endfunction

endpackage

// ===== hdl/tbcr_front.sv =====
// Front end: accepts items, tracks pending events, window and chord hold.
// Emits at most one bundle of up to four actions per accepted item. Uses tbcr_pkg.
module tbcr_front import tbcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output bundle_t    q_data_o
);

  logic [15:0] win_q;
  logic [3:0]  p1_q, p1_d, p2_q, p2_d;
  logic [31:0] ws_q, ws_d;
  logic        wo_q, wo_d, chord_q, chord_d;
  logic        accept;
  bundle_t     bund;

  function automatic bundle_t push_act(bundle_t b, logic [1:0] lamp, logic [3:0] ev);
    bundle_t  r;
    act_map_t m;
    r = b;
    m = action_of(ev);
    if (m.vld && (b.count < CntW'(MaxActs))) begin
      r.slots[b.count[SlotW-1:0]].lamp   = lamp;
      r.slots[b.count[SlotW-1:0]].action = m.code;
      r.count = b.count + CntW'(1);
    end
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic [3:0]  e1, e2, fin, ev;
    logic [31:0] diff;
    e1 = clean_event(in_item_i.button1_event);
    e2 = clean_event(in_item_i.button2_event);
    fin = EV_NONE;
    ev  = EV_NONE;
    diff = '0;
    p1_d = p1_q;
    p2_d = p2_q;
    ws_d = ws_q;
    wo_d = wo_q;
    chord_d = chord_q;
    bund = '0;
    if (chord_q) begin
      if ((e1 == EV_HOLD_END || e1 == EV_CLICK_HOLD_END) && e1 == p1_d) begin
        fin  = e1;
        p1_d = EV_NONE;
      end
      if ((e2 == EV_HOLD_END || e2 == EV_CLICK_HOLD_END) && e2 == p2_d) begin
        fin  = e2;
        p2_d = EV_NONE;
      end
      if (p1_d == EV_NONE && p2_d == EV_NONE) begin
        bund = push_act(bund, LAMP_THREE, fin);
        ws_d = '0;
        wo_d = 1'b0;
        chord_d = 1'b0;
      end
    end else begin
      if (e1 != EV_NONE) begin
        if (!wo_d) begin
          wo_d = 1'b1;
          ws_d = in_item_i.now_ms;
        end
        if (p1_d != EV_NONE) bund = push_act(bund, LAMP_ONE, p1_d);
        p1_d = e1;
      end
      if (e2 != EV_NONE) begin
        if (!wo_d) begin
          wo_d = 1'b1;
          ws_d = in_item_i.now_ms;
        end
        if (p2_d != EV_NONE) bund = push_act(bund, LAMP_TWO, p2_d);
        p2_d = e2;
      end
      if (wo_d) begin
        diff = in_item_i.now_ms - ws_d;
        if (diff > {16'd0, win_q}) begin
          if (p1_d != EV_NONE) bund = push_act(bund, LAMP_ONE, p1_d);
          if (p2_d != EV_NONE) bund = push_act(bund, LAMP_TWO, p2_d);
          p1_d = EV_NONE;
          p2_d = EV_NONE;
          ws_d = '0;
          wo_d = 1'b0;
        end else if (p1_d != EV_NONE && p1_d == p2_d) begin
          ev = p1_d;
          bund = push_act(bund, LAMP_THREE, ev);
          p1_d = EV_NONE;
          p2_d = EV_NONE;
          ws_d = '0;
          wo_d = 1'b0;
          if (ev == EV_HOLD_START) begin
            chord_d = 1'b1;
            p1_d = EV_HOLD_END;
            p2_d = EV_HOLD_END;
          end else if (ev == EV_CLICK_HOLD_START) begin
            chord_d = 1'b1;
            p1_d = EV_CLICK_HOLD_END;
            p2_d = EV_CLICK_HOLD_END;
          end
        end
      end
    end
  end

  assign q_push_o = accept && (bund.count != '0);
  assign q_data_o = bund;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WIN_RESET;
      p1_q    <= EV_NONE;
      p2_q    <= EV_NONE;
      ws_q    <= '0;
      wo_q    <= 1'b0;
      chord_q <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (accept) begin
        p1_q    <= p1_d;
        p2_q    <= p2_d;
        ws_q    <= ws_d;
        wo_q    <= wo_d;
        chord_q <= chord_d;
      end
    end
  end

endmodule

// ===== hdl/tbcr_queue.sv =====
// Two-entry bundle queue between front and back ends.
// Uses tbcr_pkg for the bundle type.
module tbcr_queue import tbcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output bundle_t data_o
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/tbcr_back.sv =====
// Back end: plays out each queued bundle as one action item per cycle unless stalled.
// Marks the final action of a bundle with last. Uses tbcr_pkg.
module tbcr_back import tbcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  bundle_t   q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  bundle_t          bund_q, bund_d;
  logic             busy_q, busy_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic             is_last, taken;

  assign is_last = (CntW'(idx_q) + CntW'(1)) == bund_q.count;
  assign taken   = busy_q && !out_stall_i;
  assign q_pop_o = q_valid_i && (!busy_q || (taken && is_last));

  assign out_valid_o            = busy_q;
  assign out_item_o.target_lamp = bund_q.slots[idx_q].lamp;
  assign out_item_o.action      = bund_q.slots[idx_q].action;
  assign out_item_o.last        = is_last;

  always_comb begin
    bund_d = bund_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      bund_d = q_data_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (taken) begin
      if (is_last) busy_d = 1'b0;
      else         idx_d  = idx_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bund_q <= bund_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// ===== hdl/two_button_chord_router.sv =====
// Two-button chord router: each bundle is registered in the queue, then in the back end.
// Throughput: one input item per cycle unless the queue is full; the output carries
// one action per cycle unless out_stall_i is high, and an item yields 0 to 4 actions.
// Bursts are absorbed by a two-bundle queue; the front stalls only when it is full.
// Reset (rst_ni, async low): no pending events, window closed, window length 300 ms.
module two_button_chord_router import tbcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic    q_full, q_push, q_pop, q_valid;
  bundle_t q_wdata, q_rdata;

  tbcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  tbcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  tbcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
